// ===== design/alir_pkg.sv =====
package alir_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W   = 32;

    localparam logic [2:0] K_INS_AT    = 3'd0;
    localparam logic [2:0] K_INS_FRONT = 3'd1;
    localparam logic [2:0] K_INS_REAR  = 3'd2;
    localparam logic [2:0] K_REM_FRONT = 3'd3;
    localparam logic [2:0] K_REM_REAR  = 3'd4;
    localparam logic [2:0] K_REM_AT    = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]        position;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [1:0]              status;
        logic [4:0]              entry_count;
        logic                    is_full;
        logic                    is_empty;
    } t_out;

endpackage

// ===== design/alir_ram.sv =====
module alir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/array_list_insert_remove.sv =====
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel: i_in_valid / o_in_stall carry one operation per transaction
// (insert at position, front or rear; remove at front, rear or position).
// Output channel: o_out_valid / i_out_stall return one result per operation:
// removed value, status, count after the operation, full and empty flags.
// Entries live in a single-port-write, single-port-read RAM with registered
// read. One sequencer moves one entry at a time (read, then write).
// An insert moves each entry from the rear down to the position up by one,
// then writes the new value into the gap; an insert at the rear only writes
// the value. A removal first reads the removed entry, then moves each later
// entry down by one; an error or unassigned kind goes straight to the result.
// The input stalls while an operation is in progress and accepts again in the
// cycle after the result is registered. A finished result sits in the output
// register; the next transaction may be accepted while it waits, and that one
// holds at its last step until the receiver takes the earlier result.
// Reset empties the list (count zero); RAM contents are not cleared, since
// only entries below the count are ever read.
module array_list_insert_remove (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  alir_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output alir_pkg::t_out o_out_data
);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_WR, S_PUT, S_DONE} t_state;

    localparam int IW = alir_pkg::IDX_W;
    localparam int CW = alir_pkg::CNT_W;
    localparam int MW = alir_pkg::CMP_W;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic [CW-1:0]                 r_new_cnt, n_new_cnt;
    logic [IW-1:0]                 r_src, n_src;
    logic [IW-1:0]                 r_dst, n_dst;
    logic [IW-1:0]                 r_stop, n_stop;
    logic                          r_is_ins, n_is_ins;
    logic                          r_grab, n_grab;
    logic [1:0]                    r_status, n_status;
    logic [alir_pkg::DATA_W-1:0]   r_value, n_value;
    logic [alir_pkg::DATA_W-1:0]   r_taken, n_taken;
    logic                          r_out_valid, n_out_valid;
    alir_pkg::t_out                r_out, n_out;

    logic                          ram_we, ram_re;
    logic [IW-1:0]                 ram_waddr, ram_raddr;
    logic [alir_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;

    logic                          accept;
    logic                          out_free;
    logic [MW-1:0]                 cnt_m, pos_eff;
    logic                          kind_ins, kind_rem;

    alir_ram #(
        .WIDTH(alir_pkg::DATA_W),
        .DEPTH(alir_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign cnt_m       = MW'(r_cnt);

    always_comb begin
        kind_ins = 1'b0;
        kind_rem = 1'b0;
        pos_eff  = MW'(i_in_data.position);
        unique case (i_in_data.kind)
            alir_pkg::K_INS_AT: begin
                kind_ins = 1'b1;
            end
            alir_pkg::K_INS_FRONT: begin
                kind_ins = 1'b1;
                pos_eff  = '0;
            end
            alir_pkg::K_INS_REAR: begin
                kind_ins = 1'b1;
                pos_eff  = cnt_m;
            end
            alir_pkg::K_REM_FRONT: begin
                kind_rem = 1'b1;
                pos_eff  = '0;
            end
            alir_pkg::K_REM_REAR: begin
                kind_rem = 1'b1;
                pos_eff  = cnt_m - MW'(1);
            end
            alir_pkg::K_REM_AT: begin
                kind_rem = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_new_cnt   = r_new_cnt;
        n_src       = r_src;
        n_dst       = r_dst;
        n_stop      = r_stop;
        n_is_ins    = r_is_ins;
        n_grab      = r_grab;
        n_status    = r_status;
        n_value     = r_value;
        n_taken     = r_taken;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_dst;
        ram_raddr   = r_src;
        ram_wdata   = ram_rdata;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_value   = i_in_data.value;
                    n_taken   = '0;
                    n_status  = alir_pkg::ST_OK;
                    n_new_cnt = r_cnt;
                    n_is_ins  = kind_ins;
                    n_grab    = 1'b0;
                    n_stop    = IW'(pos_eff);
                    n_state   = S_DONE;
                    if (kind_ins) begin
                        if (cnt_m >= MW'(alir_pkg::CAPACITY)) begin
                            n_status = alir_pkg::ST_FULL;
                        end else if (pos_eff > cnt_m) begin
                            n_status = alir_pkg::ST_RANGE;
                        end else begin
                            n_new_cnt = r_cnt + CW'(1);
                            n_src     = IW'(cnt_m - MW'(1));
                            n_dst     = IW'(cnt_m);
                            n_state   = (pos_eff == cnt_m) ? S_PUT : S_RD;
                        end
                    end else if (kind_rem) begin
                        if (r_cnt == '0) begin
                            n_status = alir_pkg::ST_EMPTY;
                        end else if (pos_eff >= cnt_m) begin
                            n_status = alir_pkg::ST_RANGE;
                        end else begin
                            n_new_cnt = r_cnt - CW'(1);
                            n_src     = IW'(pos_eff);
                            n_grab    = 1'b1;
                            n_state   = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                if (r_is_ins) begin
                    // move entry src up to dst, walking down toward the gap
                    ram_we = 1'b1;
                    if (r_src == r_stop) begin
                        n_state = S_PUT;
                    end else begin
                        n_src   = r_src - IW'(1);
                        n_dst   = r_dst - IW'(1);
                        n_state = S_RD;
                    end
                end else begin
                    if (r_grab) begin
                        n_taken = ram_rdata;
                        n_grab  = 1'b0;
                    end else begin
                        ram_we = 1'b1;
                    end
                    // close the gap: pull the next entry down
                    if ((CW'(r_src) + CW'(1)) < r_cnt) begin
                        n_dst   = r_src;
                        n_src   = r_src + IW'(1);
                        n_state = S_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_stop;
                ram_wdata = r_value;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.removed_value  = r_taken;
                    n_out.status         = r_status;
                    n_out.entry_count    = 5'(r_new_cnt);
                    n_out.is_full        = (r_new_cnt == CW'(alir_pkg::CAPACITY));
                    n_out.is_empty       = (r_new_cnt == '0);
                    n_cnt                = r_new_cnt;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_new_cnt <= n_new_cnt;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_stop    <= n_stop;
        r_is_ins  <= n_is_ins;
        r_grab    <= n_grab;
        r_status  <= n_status;
        r_value   <= n_value;
        r_taken   <= n_taken;
        r_out     <= n_out;
    end

endmodule
